// ===== src/owbm_pkg.sv =====
// owbm_pkg: types and constants shared by the single-wire bus master timing block
// holds the beat structs, command and phase encodings, config layout and queue sizing
// no dependencies
package owbm_pkg;

	// command beat as it arrives on the input channel
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data;
		logic       line_level;
	} in_t;

	// result beat as it leaves on the output channel
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
		logic       presence_level;
	} res_t;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_RESET = 3'd1,
		OP_WBIT  = 3'd2,
		OP_RBIT  = 3'd3,
		OP_WBYTE = 3'd4,
		OP_RBYTE = 3'd5
	} op_e;

	// classified beat held in the queue between front and engine
	typedef struct packed {
		op_e        op;
		logic [7:0] data;
		logic       line_level;
	} item_t;

	typedef enum logic [7:0] {
		PH_IDLE     = 8'b0000_0001,
		PH_RST_LOW  = 8'b0000_0010,
		PH_RST_WAIT = 8'b0000_0100,
		PH_RST_REC  = 8'b0000_1000,
		PH_SLOT_LOW = 8'b0001_0000,
		PH_SLOT_REL = 8'b0010_0000,
		PH_ZERO_LOW = 8'b0100_0000,
		PH_GAP      = 8'b1000_0000
	} phase_e;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [9:0] presence_wait_us;
		logic [9:0] reset_recovery_us;
		logic [7:0] slot_low_us;
		logic [7:0] write_zero_low_us;
		logic [7:0] write_one_release_us;
		logic [7:0] read_release_us;
		logic [7:0] bit_gap_us;
	} cfg_t;

	// register map, word index = paddr[4:2]
	localparam int unsigned CFG_AW = 5;
	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] REG_RESET_REC     = 3'd2;
	localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
	localparam logic [2:0] REG_ZERO_LOW      = 3'd4;
	localparam logic [2:0] REG_ONE_RELEASE   = 3'd5;
	localparam logic [2:0] REG_READ_RELEASE  = 3'd6;
	localparam logic [2:0] REG_BIT_GAP       = 3'd7;

	localparam cfg_t CFG_RESET = '{
		reset_low_us:         10'd500,
		presence_wait_us:     10'd60,
		reset_recovery_us:    10'd600,
		slot_low_us:          8'd5,
		write_zero_low_us:    8'd80,
		write_one_release_us: 8'd60,
		read_release_us:      8'd70,
		bit_gap_us:           8'd5
	};

	// queue between front and engine, depth must be a power of two
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

endpackage

// ===== src/owbm_front.sv =====
// owbm_front: input side of the bus master, takes command beats and classifies them
// unknown operation codes become plain ticks; depends on owbm_pkg
module owbm_front import owbm_pkg::*; (
	input  logic  cmd_valid,
	output logic  cmd_stall,
	input  in_t   cmd,
	input  logic  q_full,
	output logic  q_push,
	output item_t q_item
);

	op_e op_cls;

	always_comb begin
		case (cmd.operation)
			OP_RESET: op_cls = OP_RESET;
			OP_WBIT:  op_cls = OP_WBIT;
			OP_RBIT:  op_cls = OP_RBIT;
			OP_WBYTE: op_cls = OP_WBYTE;
			OP_RBYTE: op_cls = OP_RBYTE;
			default:  op_cls = OP_TICK;
		endcase
	end

	assign cmd_stall         = q_full;
	assign q_push            = cmd_valid & ~q_full;
	assign q_item.op         = op_cls;
	assign q_item.data       = cmd.data;
	assign q_item.line_level = cmd.line_level;

endmodule

// ===== src/owbm_queue.sv =====
// owbm_queue: short fifo of classified beats between front and engine
// depth set by QDEPTH in owbm_pkg
module owbm_queue import owbm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCW'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ptr_match_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("queue empty but pointers differ");
	a_push_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");
`endif

endmodule

// ===== src/owbm_engine.sv =====
// owbm_engine: back end of the bus master, steps the slot timing one beat per cycle when
// not stalled; holds phase timer, bit counter, shifters, result register; uses owbm_pkg
module owbm_engine import owbm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t head,
	input  logic  q_empty,
	output logic  q_pop,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	typedef struct packed {
		phase_e     phase;
		logic [9:0] timer;
		logic [3:0] bit_index;
		op_e        kind;
		logic [7:0] shift_data;
		logic [7:0] read_shift;
		logic       presence;
		logic       done;
	} eng_t;

	// longest chain of zero-length phases plus the closing decrement
	localparam int unsigned NSTEP = 4;

	eng_t st_q;
	eng_t st_nxt;
	logic res_valid_q;
	res_t res_q;

	function automatic logic [7:0] max1_8(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic logic [9:0] max1_10(input logic [9:0] v);
		return (v == 10'd0) ? 10'd1 : v;
	endfunction

	function automatic logic is_read(input op_e k);
		return (k == OP_RBIT) || (k == OP_RBYTE);
	endfunction

	function automatic eng_t start_slot(input eng_t s, input cfg_t c);
		eng_t r;
		r = s;
		if (is_read(s.kind) || s.shift_data[s.bit_index[2:0]]) begin
			r.phase = PH_SLOT_LOW;
			r.timer = {2'b00, max1_8(c.slot_low_us)};
		end else begin
			r.phase = PH_ZERO_LOW;
			r.timer = {2'b00, max1_8(c.write_zero_low_us)};
		end
		return r;
	endfunction

	function automatic eng_t next_bit(input eng_t s, input cfg_t c);
		eng_t       r;
		logic [3:0] nbits;
		r = s;
		nbits = ((s.kind == OP_WBYTE) || (s.kind == OP_RBYTE)) ? 4'd8 : 4'd1;
		r.bit_index = s.bit_index + 4'd1;
		if (r.bit_index >= nbits) begin
			r.phase = PH_IDLE;
			r.timer = '0;
			r.done  = 1'b1;
		end else begin
			r = start_slot(r, c);
		end
		return r;
	endfunction

	function automatic eng_t finish(input eng_t s, input cfg_t c, input logic line);
		eng_t r;
		r = s;
		case (s.phase)
			PH_RST_LOW: begin
				r.phase = PH_RST_WAIT;
				r.timer = c.presence_wait_us;
			end
			PH_RST_WAIT: begin
				r.presence = line;
				r.phase    = PH_RST_REC;
				r.timer    = c.reset_recovery_us;
			end
			PH_RST_REC: begin
				r.phase = PH_IDLE;
				r.timer = '0;
				r.done  = 1'b1;
			end
			PH_SLOT_LOW: begin
				r.phase = PH_SLOT_REL;
				if (is_read(s.kind)) begin
					r.read_shift[s.bit_index[2:0]] = s.read_shift[s.bit_index[2:0]] | line;
					r.timer = {2'b00, c.read_release_us};
				end else begin
					r.timer = {2'b00, c.write_one_release_us};
				end
			end
			PH_SLOT_REL: begin
				if (is_read(s.kind)) begin
					r = next_bit(s, c);
				end else begin
					r.phase = PH_GAP;
					r.timer = {2'b00, c.bit_gap_us};
				end
			end
			PH_ZERO_LOW: begin
				r.phase = PH_GAP;
				r.timer = {2'b00, c.bit_gap_us};
			end
			PH_GAP: begin
				r = next_bit(s, c);
			end
			default: begin
				r.phase = PH_IDLE;
				r.timer = '0;
			end
		endcase
		return r;
	endfunction

	function automatic eng_t step(input eng_t s0, input item_t it, input cfg_t c);
		eng_t s;
		logic stop;
		s = s0;
		s.done = 1'b0;
		stop = 1'b0;
		if (s.phase == PH_IDLE && it.op != OP_TICK) begin
			s.kind       = it.op;
			s.shift_data = it.data;
			s.bit_index  = '0;
			if (it.op == OP_RESET) begin
				s.phase = PH_RST_LOW;
				s.timer = max1_10(c.reset_low_us);
			end else begin
				if (is_read(it.op)) begin
					s.read_shift = '0;
				end
				s = start_slot(s, c);
			end
		end
		// walk through phases that end on this beat, stop at the first running timer
		for (int k = 0; k < NSTEP; k++) begin
			if (!stop && s.phase != PH_IDLE) begin
				if (s.timer != '0) begin
					s.timer = s.timer - 10'd1;
					stop = 1'b1;
				end else begin
					s = finish(s, c, it.line_level);
				end
			end
		end
		return s;
	endfunction

	assign q_pop  = ~q_empty & (~res_valid_q | ~res_stall);
	assign st_nxt = step(st_q, head, cfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.timer      <= '0;
			st_q.bit_index  <= '0;
			st_q.kind       <= OP_TICK;
			st_q.shift_data <= '0;
			st_q.read_shift <= '0;
			st_q.presence   <= 1'b1;
			st_q.done       <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				st_q        <= st_nxt;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.drive_low      <= (st_nxt.phase == PH_RST_LOW) || (st_nxt.phase == PH_SLOT_LOW)
				|| (st_nxt.phase == PH_ZERO_LOW);
			res_q.busy_res       <= (st_nxt.phase != PH_IDLE);
			res_q.done_res       <= st_nxt.done;
			res_q.read_value     <= st_nxt.read_shift;
			res_q.presence_level <= st_nxt.presence;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q.phase))
		else $error("phase register not one-hot");
	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE) |-> (st_q.timer == '0))
		else $error("timer running while idle");
	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> (!res_q.busy_res && !res_q.drive_low))
		else $error("done beat still busy or driving");
	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_index <= 4'd8)
		else $error("bit index past a byte");
`endif

endmodule

// ===== src/onewire_bus_master_timing_top.sv =====
// onewire_bus_master_timing_top: single-wire bus master timing, one microsecond per beat
// path: an accepted beat is registered in the queue, then popped into the engine state and result register
// throughput: one beat per cycle unless res_stall holds it, set by the combinational phase step; queue is 4 deep
// reset: arst_n async low; phase idle, presence 1, queue and result register empty,
// config registers back to their defaults; no clearing pass
module onewire_bus_master_timing_top import owbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  in_t               cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       cfg_wr;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	item_t      q_item;
	item_t      q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RESET_LOW:     cfg_q.reset_low_us         <= pwdata[9:0];
				REG_PRESENCE_WAIT: cfg_q.presence_wait_us     <= pwdata[9:0];
				REG_RESET_REC:     cfg_q.reset_recovery_us    <= pwdata[9:0];
				REG_SLOT_LOW:      cfg_q.slot_low_us          <= pwdata[7:0];
				REG_ZERO_LOW:      cfg_q.write_zero_low_us    <= pwdata[7:0];
				REG_ONE_RELEASE:   cfg_q.write_one_release_us <= pwdata[7:0];
				REG_READ_RELEASE:  cfg_q.read_release_us      <= pwdata[7:0];
				REG_BIT_GAP:       cfg_q.bit_gap_us           <= pwdata[7:0];
				default:           cfg_q                      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RESET_LOW:     prdata = {22'd0, cfg_q.reset_low_us};
			REG_PRESENCE_WAIT: prdata = {22'd0, cfg_q.presence_wait_us};
			REG_RESET_REC:     prdata = {22'd0, cfg_q.reset_recovery_us};
			REG_SLOT_LOW:      prdata = {24'd0, cfg_q.slot_low_us};
			REG_ZERO_LOW:      prdata = {24'd0, cfg_q.write_zero_low_us};
			REG_ONE_RELEASE:   prdata = {24'd0, cfg_q.write_one_release_us};
			REG_READ_RELEASE:  prdata = {24'd0, cfg_q.read_release_us};
			REG_BIT_GAP:       prdata = {24'd0, cfg_q.bit_gap_us};
			default:           prdata = '0;
		endcase
	end

	owbm_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	owbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	owbm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== tb/owbm_checker.sv =====
`timescale 1ns / 100ps
// owbm_checker: predicts the bus master's result beat for every accepted command beat
// and compares it with the result channel; tracks config writes on the register port
// depends on owbm_pkg
module owbm_checker import owbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  in_t               cmd,
	input  logic              res_valid,
	input  logic              res_stall,
	input  res_t              res,
	output int                mismatches,
	output int                pending,
	output logic              bus_idle
);

	cfg_t       cfg;
	phase_e     ph;
	logic [9:0] tmr;
	logic [3:0] bit_idx;
	logic [2:0] kind;
	logic [7:0] wr_byte;
	logic [7:0] rd_byte;
	logic       pres;
	logic       done_now;
	res_t       bus_result_q[$];

	assign bus_idle = (ph == PH_IDLE);

	function automatic logic [9:0] min1(input logic [9:0] v);
		return (v == 10'd0) ? 10'd1 : v;
	endfunction

	function automatic logic rd_cmd();
		return kind == OP_RBIT || kind == OP_RBYTE;
	endfunction

	task automatic enter_phase(input phase_e p, input logic [9:0] dur);
		ph = p;
		tmr = dur;
	endtask

	task automatic begin_slot();
		if (rd_cmd() || wr_byte[bit_idx[2:0]])
			enter_phase(PH_SLOT_LOW, min1({2'b00, cfg.slot_low_us}));
		else
			enter_phase(PH_ZERO_LOW, min1({2'b00, cfg.write_zero_low_us}));
	endtask

	task automatic step_bit();
		logic [3:0] nbits;
		nbits = (kind == OP_WBYTE || kind == OP_RBYTE) ? 4'd8 : 4'd1;
		bit_idx = bit_idx + 4'd1;
		if (bit_idx >= nbits) begin
			enter_phase(PH_IDLE, 10'd0);
			done_now = 1'b1;
		end else begin
			begin_slot();
		end
	endtask

	task automatic end_phase(input logic line);
		case (ph)
			PH_RST_LOW: enter_phase(PH_RST_WAIT, cfg.presence_wait_us);
			PH_RST_WAIT: begin
				pres = line;
				enter_phase(PH_RST_REC, cfg.reset_recovery_us);
			end
			PH_RST_REC: begin
				enter_phase(PH_IDLE, 10'd0);
				done_now = 1'b1;
			end
			PH_SLOT_LOW: begin
				if (rd_cmd()) begin
					rd_byte[bit_idx[2:0]] = rd_byte[bit_idx[2:0]] | line;
					enter_phase(PH_SLOT_REL, {2'b00, cfg.read_release_us});
				end else begin
					enter_phase(PH_SLOT_REL, {2'b00, cfg.write_one_release_us});
				end
			end
			PH_SLOT_REL: begin
				if (rd_cmd())
					step_bit();
				else
					enter_phase(PH_GAP, {2'b00, cfg.bit_gap_us});
			end
			PH_ZERO_LOW: enter_phase(PH_GAP, {2'b00, cfg.bit_gap_us});
			PH_GAP: step_bit();
			default: enter_phase(PH_IDLE, 10'd0);
		endcase
	endtask

	// zero-length phases fall through inside the same microsecond
	task automatic spend_tick(input logic line);
		while (ph != PH_IDLE) begin
			if (tmr != 10'd0) begin
				tmr = tmr - 10'd1;
				return;
			end
			end_phase(line);
		end
	endtask

	task automatic bus_tick(input in_t c, output res_t r);
		done_now = 1'b0;
		if (ph == PH_IDLE && c.operation >= OP_RESET && c.operation <= OP_RBYTE) begin
			kind = c.operation;
			wr_byte = c.data;
			bit_idx = 4'd0;
			if (c.operation == OP_RESET) begin
				enter_phase(PH_RST_LOW, min1(cfg.reset_low_us));
			end else begin
				if (c.operation == OP_RBIT || c.operation == OP_RBYTE)
					rd_byte = 8'd0;
				begin_slot();
			end
		end
		spend_tick(c.line_level);
		r.drive_low = (ph == PH_RST_LOW || ph == PH_SLOT_LOW || ph == PH_ZERO_LOW);
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done_now;
		r.read_value = rd_byte;
		r.presence_level = pres;
	endtask

	task automatic diff_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t nxt;
		res_t want;
		if (!arst_n) begin
			cfg = CFG_RESET;
			ph = PH_IDLE;
			tmr = '0;
			bit_idx = '0;
			kind = '0;
			wr_byte = '0;
			rd_byte = '0;
			pres = 1'b1;
			done_now = 1'b0;
			bus_result_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_RESET_LOW:     cfg.reset_low_us = pwdata[9:0];
					REG_PRESENCE_WAIT: cfg.presence_wait_us = pwdata[9:0];
					REG_RESET_REC:     cfg.reset_recovery_us = pwdata[9:0];
					REG_SLOT_LOW:      cfg.slot_low_us = pwdata[7:0];
					REG_ZERO_LOW:      cfg.write_zero_low_us = pwdata[7:0];
					REG_ONE_RELEASE:   cfg.write_one_release_us = pwdata[7:0];
					REG_READ_RELEASE:  cfg.read_release_us = pwdata[7:0];
					REG_BIT_GAP:       cfg.bit_gap_us = pwdata[7:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				bus_tick(cmd, nxt);
				bus_result_q.push_back(nxt);
			end
			if (res_valid && !res_stall) begin
				if (bus_result_q.size() == 0) begin
					$display("%0t: result beat with none expected, actual %0h", $time, res);
					mismatches++;
				end else begin
					want = bus_result_q.pop_front();
					diff_field("drive_low", 32'(want.drive_low), 32'(res.drive_low));
					diff_field("busy_res", 32'(want.busy_res), 32'(res.busy_res));
					diff_field("done_res", 32'(want.done_res), 32'(res.done_res));
					diff_field("read_value", 32'(want.read_value), 32'(res.read_value));
					diff_field("presence_level", 32'(want.presence_level),
						32'(res.presence_level));
				end
			end
			pending = bus_result_q.size();
		end
	end

endmodule

// ===== tb/tb_onewire_bus_master_timing_top.sv =====
`timescale 1ns / 100ps
// tb_onewire_bus_master_timing_top: stimulus and verdict for the single-wire bus master
// drives command beats, timing registers and result stalls; checking lives in owbm_checker
// depends on owbm_pkg, owbm_checker and onewire_bus_master_timing_top
module tb_onewire_bus_master_timing_top;
	import owbm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	// operation codes outside the command set, handled as plain ticks
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              cmd_valid;
	logic              cmd_stall;
	in_t               cmd;
	logic              res_valid;
	logic              res_stall;
	res_t              res;

	int   mismatches;
	int   pending;
	logic bus_idle;
	logic cmd_taken;
	logic apb_taken;
	bit   calm;
	cfg_t timing;
	int   quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	onewire_bus_master_timing_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	owbm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.mismatches(mismatches), .pending(pending), .bus_idle(bus_idle)
	);

	// handshakes seen at the rising edge, read back at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_taken <= 1'b0;
			apb_taken <= 1'b0;
		end else begin
			cmd_taken <= cmd_valid && !cmd_stall;
			apb_taken <= psel && penable && pwrite && pready;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("onewire_bus_master_timing_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side back-pressure: mostly short stalls, a few long ones
	initial begin : stall_gen
		int stall_left;
		stall_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 99) < 25)
				stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					: $urandom_range(15, 40);
			res_stall <= (stall_left > 0);
		end
	end

	function automatic int at_least_one(input int v);
		return (v == 0) ? 1 : v;
	endfunction

	// rough length of a command in microseconds under the current timing
	function automatic int cmd_span(input logic [2:0] op);
		int slot;
		slot = at_least_one(at_least_one(timing.slot_low_us) > timing.write_zero_low_us
			? timing.slot_low_us : timing.write_zero_low_us)
			+ ((timing.write_one_release_us > timing.read_release_us)
			? timing.write_one_release_us : timing.read_release_us)
			+ timing.bit_gap_us + 1;
		case (op)
			OP_RESET: return at_least_one(timing.reset_low_us) + timing.presence_wait_us
				+ timing.reset_recovery_us + 1;
			OP_WBIT, OP_RBIT: return slot;
			OP_WBYTE, OP_RBYTE: return 8 * slot;
			default: return 0;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic line);
		int gap;
		in_t beat;
		gap = pick_gap();
		beat.operation = op;
		beat.data = data;
		beat.line_level = line;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= beat;
		do @(negedge clk); while (!cmd_taken);
	endtask

	// ticks until the command in flight has finished; mode 0 or 1 holds the line, 2 randomizes
	task automatic drain_bus(input int mode);
		logic lv;
		while (!bus_idle) begin
			lv = (mode == 2) ? 1'($urandom_range(0, 1)) : mode[0];
			send_item(OP_TICK, 8'($urandom), lv);
		end
	endtask

	task automatic hold_until_empty();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!apb_taken);
	endtask

	task automatic load_timing(input cfg_t c);
		timing = c;
		reg_write(REG_RESET_LOW, 32'(c.reset_low_us));
		reg_write(REG_PRESENCE_WAIT, 32'(c.presence_wait_us));
		reg_write(REG_RESET_REC, 32'(c.reset_recovery_us));
		reg_write(REG_SLOT_LOW, 32'(c.slot_low_us));
		reg_write(REG_ZERO_LOW, 32'(c.write_zero_low_us));
		reg_write(REG_ONE_RELEASE, 32'(c.write_one_release_us));
		reg_write(REG_READ_RELEASE, 32'(c.read_release_us));
		reg_write(REG_BIT_GAP, 32'(c.bit_gap_us));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic cfg_t rand_timing(input int hi);
		cfg_t c;
		c.reset_low_us = 10'($urandom_range(0, hi));
		c.presence_wait_us = 10'($urandom_range(0, hi));
		c.reset_recovery_us = 10'($urandom_range(0, hi));
		c.slot_low_us = 8'($urandom_range(0, hi));
		c.write_zero_low_us = 8'($urandom_range(0, hi));
		c.write_one_release_us = 8'($urandom_range(0, hi));
		c.read_release_us = 8'($urandom_range(0, hi));
		c.bit_gap_us = 8'($urandom_range(0, hi));
		return c;
	endfunction

	function automatic logic [2:0] noise_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 90)
			return OP_TICK;
		if (r < 96)
			return r[0] ? OP_SPARE7 : OP_SPARE6;
		return 3'($urandom_range(OP_RESET, OP_RBYTE));
	endfunction

	// a command, then mostly enough ticks to finish it; now and then too few,
	// so the next command lands while busy
	task automatic run_traffic(input int n_cmds);
		int r;
		int ticks;
		logic [2:0] op;
		for (int i = 0; i < n_cmds; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 20) ? OP_RESET : (r < 35) ? OP_WBIT : (r < 50) ? OP_RBIT
				: (r < 75) ? OP_WBYTE : OP_RBYTE;
			send_item(op, 8'($urandom), 1'($urandom));
			ticks = ($urandom_range(0, 9) < 8) ? cmd_span(op) + $urandom_range(0, 3)
				: $urandom_range(0, cmd_span(op));
			repeat (ticks) send_item(noise_op(), 8'($urandom), 1'($urandom));
			if ($urandom_range(0, 29) == 0)
				hold_until_empty();
		end
		drain_bus(2);
		hold_until_empty();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		calm = 1'b1;
		timing = CFG_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset timing, no register writes yet
		send_item(OP_WBIT, 8'h01, 1'b1);
		drain_bus(2);
		send_item(OP_RBIT, 8'h00, 1'b1);
		drain_bus(0);
		hold_until_empty();

		calm = 1'b0;
		load_timing('{reset_low_us: 10'd3, presence_wait_us: 10'd2, reset_recovery_us: 10'd4,
			slot_low_us: 8'd2, write_zero_low_us: 8'd4, write_one_release_us: 8'd3,
			read_release_us: 8'd3, bit_gap_us: 8'd1});
		send_item(OP_WBYTE, 8'hFF, 1'b1);
		drain_bus(2);
		send_item(OP_WBYTE, 8'h00, 1'b0);
		drain_bus(2);
		send_item(OP_RBYTE, 8'h00, 1'b1);
		drain_bus(1);
		send_item(OP_RBYTE, 8'hFF, 1'b0);
		drain_bus(0);
		send_item(OP_RBIT, 8'h00, 1'b1);
		drain_bus(1);
		send_item(OP_RESET, 8'h00, 1'b0);
		drain_bus(0);
		send_item(OP_RESET, 8'hFF, 1'b1);
		drain_bus(1);
		// commands while busy are ignored, spare codes are ticks
		send_item(OP_WBYTE, 8'hA5, 1'b0);
		send_item(OP_RESET, 8'h00, 1'b0);
		send_item(OP_RBYTE, 8'h00, 1'b1);
		send_item(OP_SPARE6, 8'h5A, 1'b1);
		send_item(OP_SPARE7, 8'hC3, 1'b0);
		drain_bus(2);
		send_item(OP_SPARE7, 8'h00, 1'b1);
		send_item(OP_SPARE6, 8'h00, 1'b0);
		send_item(OP_TICK, 8'hFF, 1'b1);
		hold_until_empty();

		// zero low times act as one, zero waits pass straight through
		load_timing('0);
		send_item(OP_RESET, 8'h00, 1'b0);
		drain_bus(2);
		send_item(OP_WBYTE, 8'h3C, 1'b1);
		drain_bus(2);
		send_item(OP_RBYTE, 8'h00, 1'b1);
		drain_bus(2);
		send_item(OP_WBIT, 8'h00, 1'b1);
		drain_bus(2);
		send_item(OP_RBIT, 8'h00, 1'b0);
		send_item(OP_WBIT, 8'h01, 1'b1);
		drain_bus(2);
		hold_until_empty();

		// widest register values, one long read slot with zero release
		load_timing('{reset_low_us: 10'd1023, presence_wait_us: 10'd1023,
			reset_recovery_us: 10'd1023, slot_low_us: 8'd255, write_zero_low_us: 8'd255,
			write_one_release_us: 8'd0, read_release_us: 8'd0, bit_gap_us: 8'd0});
		send_item(OP_RBIT, 8'h00, 1'b1);
		drain_bus(2);
		hold_until_empty();

		for (int p = 0; p < 4; p++) begin
			calm = (p == 2);
			load_timing(rand_timing((p == 3) ? 6 : 3));
			run_traffic((p == 3) ? 2 : 4);
		end

		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("onewire_bus_master_timing_top test passed");
		else
			$display("onewire_bus_master_timing_top test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/owbm_pkg.sv
src/owbm_front.sv
src/owbm_queue.sv
src/owbm_engine.sv
src/onewire_bus_master_timing_top.sv
tb/owbm_checker.sv
tb/tb_onewire_bus_master_timing_top.sv
